@@ src/qdec_pkg.sv @@
// shared types, constants and the transition table for the quadrature decoder
// no dependencies; imported by every module of the block

package qdec_pkg;

   // width of the wrapping position counter
   localparam int COUNT_WIDTH = 32;

   // register indexes of the control port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDOFF = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STALE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE   = 2'd2;

   // register reset values
   localparam logic [15:0] HOLDOFF_RESET = 16'd1000;
   localparam logic [31:0] STALE_RESET   = 32'd3000000;
   localparam logic [31:0] SCALE_RESET   = 32'd1000000;

   // request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // step kinds reported with each response
   typedef enum logic [2:0] {
      KIND_HELD = 3'd0,
      KIND_FWD  = 3'd1,
      KIND_BACK = 3'd2,
      KIND_SAME = 3'd3,
      KIND_BAD  = 3'd4
   } qdec_kind_type;

   // saturation limits of the signed 32-bit results
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // control register set
   typedef struct packed {
      logic [15:0] min_gap_us;
      logic [31:0] stale_us;
      logic [31:0] speed_scale;
   } qdec_cfg_type;

   // x4 transition table: previous phases (a,b) high, current phases low
   function automatic qdec_kind_type classify(input logic [3:0] code);
      qdec_kind_type kind;
      case (code) inside
         4'b0010, 4'b1011, 4'b1101, 4'b0100: kind = KIND_FWD;
         4'b0001, 4'b0111, 4'b1110, 4'b1000: kind = KIND_BACK;
         4'b0000, 4'b0101, 4'b1010, 4'b1111: kind = KIND_SAME;
         default:                            kind = KIND_BAD;
      endcase
      return kind;
   endfunction

endpackage

@@ src/qdec_csr.sv @@
// control registers of the quadrature decoder: hold-off, stale age, speed scale
// depends on qdec_pkg

module qdec_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qdec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data,
   output qdec_pkg::qdec_cfg_type               cfg
);
   import qdec_pkg::*;

   qdec_cfg_type cfg_ff, cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HOLDOFF: cfg_in.min_gap_us  = csr_data[15:0];
            CSR_STALE:   cfg_in.stale_us    = csr_data;
            CSR_SCALE:   cfg_in.speed_scale = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_gap_us  <= HOLDOFF_RESET;
         cfg_ff.stale_us    <= STALE_RESET;
         cfg_ff.speed_scale <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/qdec_div.sv @@
// serial restoring divider, unsigned 32 by 32, one quotient bit per cycle
// depends on qdec_pkg

module qdec_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import qdec_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvsr_ff, dvsr_in;
   logic [33:0] trial;
   logic        fits;

   // trial subtract of the shifted partial remainder
   assign trial = {1'b0, rem_ff, quo_ff[31]} - {2'b00, dvsr_ff};
   assign fits  = ~trial[33];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out at the top, quotient bits in at the bottom
         quo_in   = {quo_ff[30:0], fits};
         rem_in   = fits ? trial[31:0] : {rem_ff[30:0], quo_ff[31]};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/quadrature_decoder_with_speed_core.sv @@
// x4 quadrature decoder with step period and speed, top level and sequencer
// depends on qdec_pkg, qdec_csr and qdec_div
//
//  channel  dir  handshake               transaction
//  req_     in   req_tvalid/req_tready   phase sample or position load
//  rsp_     out  rsp_tvalid/rsp_tready   position, errors, period, speed, kind
//  csr_     in   csr_valid/csr_ready     control register write
//
// only a non-zero, fresh period starts the serial divider. req_tready is high
// only while the sequencer is idle; a finished response waits in the output
// register, and the next request is taken meanwhile. reset is synchronous and
// clears the sequencer, position, errors, phases, step time, period and
// response valid; registers return to their defaults.

module quadrature_decoder_with_speed_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // time_us[62:0], phase_a[63], phase_b[64], load_value[96:65], zero fill
   input  logic [103:0]                         req_tdata,
   // opcode[0]
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // position[31:0], error_count[63:32], period_us[95:64], speed[127:96]
   output logic [127:0]                         rsp_tdata,
   // step_kind[2:0]
   output logic [2:0]                           rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qdec_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                          csr_data
);
   import qdec_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SPEED,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   qdec_cfg_type cfg;

   state_type        state_ff, state_in;
   // latched request
   logic             op_ff, op_in;
   logic [62:0]      now_ff, now_in;
   logic [1:0]       cur_ff, cur_in;
   logic [31:0]      load_ff, load_in;
   // decoder state
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [31:0]      err_ff, err_in;
   logic [1:0]       prev_ff, prev_in;
   logic [63:0]      last_ff, last_in;
   logic [31:0]      period_ff, period_in;
   qdec_kind_type    kind_ff, kind_in;
   logic             neg_ff, neg_in;
   logic [31:0]      speed_ff, speed_in;
   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [127:0]     rsp_data_ff, rsp_data_in;
   logic [2:0]       rsp_user_ff, rsp_user_in;

   logic [63:0]      dt;
   logic             dt_big;
   logic             past_holdoff;
   logic             fresh;
   logic [63:0]      load_wide;
   logic [63:0]      pos_wide;
   qdec_kind_type    code_kind;
   logic             div_start;
   logic [31:0]      div_divisor;
   logic             div_done;
   logic [31:0]      div_quotient;

   qdec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qdec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.speed_scale),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // elapsed time since the last counted step, signed
   assign dt           = {1'b0, now_ff} - last_ff;
   assign dt_big       = |dt[62:31];
   assign past_holdoff = ~dt[63] && (dt[62:0] > {47'd0, cfg.min_gap_us});
   assign fresh        = dt[63] || (dt[62:0] <= {31'd0, cfg.stale_us});
   assign code_kind    = classify({prev_ff, cur_ff});
   assign load_wide    = {{32{load_ff[31]}}, load_ff};
   assign pos_wide     = 64'(pos_ff);
   assign div_divisor  = period_ff[31] ? (32'd0 - period_ff) : period_ff;

   assign req_tready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      load_in      = load_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      period_in    = period_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               now_in   = req_tdata[62:0];
               cur_in   = {req_tdata[63], req_tdata[64]};
               load_in  = req_tdata[96:65];
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // update position, errors and period
            kind_in = KIND_HELD;
            if (op_ff == OP_LOAD) begin
               pos_in  = load_wide[COUNT_WIDTH-1:0];
               kind_in = KIND_BAD;
            end else if (past_holdoff) begin
               kind_in = code_kind;
               prev_in = cur_ff;
               case (code_kind)
                  KIND_FWD: begin
                     pos_in    = pos_ff + COUNT_WIDTH'(1);
                     period_in = dt_big ? SAT_MAX : dt[31:0];
                     last_in   = {1'b0, now_ff};
                  end
                  KIND_BACK: begin
                     pos_in    = pos_ff - COUNT_WIDTH'(1);
                     period_in = dt_big ? SAT_MIN : (32'd0 - dt[31:0]);
                     last_in   = {1'b0, now_ff};
                  end
                  KIND_BAD: begin
                     if (err_ff != '1) begin
                        err_in = err_ff + 32'd1;
                     end
                  end
                  default: begin
                     prev_in = cur_ff;
                  end
               endcase
            end
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            // staleness is judged against the updated step time
            speed_in = '0;
            neg_in   = period_ff[31];
            if (fresh && (period_ff != '0)) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               // sign and saturate the magnitude quotient
               if (neg_ff) begin
                  speed_in = (div_quotient > SAT_MIN) ? SAT_MIN
                                                      : (32'd0 - div_quotient);
               end else begin
                  speed_in = div_quotient[31] ? SAT_MAX : div_quotient;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {speed_ff, period_ff, err_ff, pos_wide[31:0]};
               rsp_user_in  = kind_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         err_ff       <= '0;
         prev_ff      <= '0;
         last_ff      <= '0;
         period_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      load_ff     <= load_in;
      kind_ff     <= kind_in;
      neg_ff      <= neg_in;
      speed_ff    <= speed_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ bench/quadrature_decoder_with_speed_core_tb.sv @@
// self-checking bench for the x4 quadrature decoder with step period and speed
// depends on qdec_pkg and quadrature_decoder_with_speed_core; a predictor
// tracks position, errors and period and checks every response transaction

module quadrature_decoder_with_speed_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qdec_pkg::*;

   // register index with no register behind it
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   localparam int          ITEMS_PER_PHASE = 330;
   localparam int          SETTLE_CYCLES   = 48;
   localparam logic [31:0] CYCLE_LIMIT     = 32'd1000000;

   // one request transaction as the stimulus sees it
   typedef struct packed {
      logic        drain_first;
      logic        opcode;
      logic [62:0] time_us;
      logic        phase_a;
      logic        phase_b;
      logic [31:0] load_value;
   } encoder_item_type;

   // decoder state kept by the predictor
   typedef struct packed {
      logic [31:0]        position;
      logic [31:0]        error_count;
      logic [1:0]         phases;
      logic [63:0]        last_step;
      logic signed [31:0] period;
   } decoder_state_type;

   // one response transaction
   typedef struct packed {
      logic [31:0]        position;
      logic [31:0]        error_count;
      logic signed [31:0] period_us;
      qdec_kind_type      kind;
      logic signed [31:0] speed;
   } decoder_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // time_us[62:0], phase_a[63], phase_b[64], load_value[96:65], zero fill
   logic [103:0] req_tdata  = '0;
   // opcode[0]
   logic [0:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // position[31:0], error_count[63:32], period_us[95:64], speed[127:96]
   logic [127:0] rsp_tdata;
   // step_kind[2:0]
   logic [2:0]   rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_data  = '0;

   qdec_cfg_type       cfg;
   decoder_state_type  track_state;
   decoder_state_type  plan_state;
   logic [63:0]        plan_now;
   logic               plan_backward;
   encoder_item_type   encoder_items[$];
   decoder_report_type predicted_reports[$];
   encoder_item_type   item_on_bus;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 mismatch_count = 0;
   logic [31:0]        cycle_count = '0;

   quadrature_decoder_with_speed_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock generation
   initial begin
      forever #2 clock = ~clock;
   end

   // cycle counter, also used to carve out stretches with no idling
   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
   end

   // run limit
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] clamp_s32(input longint value);
      if (value > 64'sd2147483647) return SAT_MAX;
      if (value < -64'sd2147483648) return SAT_MIN;
      return value[31:0];
   endfunction

   // signed microseconds from the last counted step to now
   function automatic longint elapsed_us(input logic [62:0] now, input logic [63:0] last);
      return $signed({1'b0, now}) - $signed(last);
   endfunction

   // advance the decoder state by one request and give the response it causes
   function automatic decoder_report_type decode_item(inout decoder_state_type st,
                                                      input qdec_cfg_type c,
                                                      input encoder_item_type it);
      decoder_report_type rep;
      longint             dt;
      logic [3:0]         code;
      rep.kind  = KIND_HELD;
      rep.speed = '0;
      if (it.opcode == OP_LOAD) begin
         st.position = it.load_value;
         rep.kind    = KIND_BAD;
      end else begin
         dt = elapsed_us(it.time_us, st.last_step);
         if (dt > longint'({48'd0, c.min_gap_us})) begin
            // previous phases in the high bits, current in the low bits
            code = {st.phases, it.phase_a, it.phase_b};
            case (code)
               4'b0010, 4'b1011, 4'b1101, 4'b0100: begin
                  st.position  = st.position + 32'd1;
                  st.period    = clamp_s32(dt);
                  st.last_step = {1'b0, it.time_us};
                  rep.kind     = KIND_FWD;
               end
               4'b0001, 4'b0111, 4'b1110, 4'b1000: begin
                  st.position  = st.position - 32'd1;
                  st.period    = clamp_s32(-dt);
                  st.last_step = {1'b0, it.time_us};
                  rep.kind     = KIND_BACK;
               end
               4'b0000, 4'b0101, 4'b1010, 4'b1111: begin
                  rep.kind = KIND_SAME;
               end
               default: begin
                  if (st.error_count != '1) st.error_count = st.error_count + 32'd1;
                  rep.kind = KIND_BAD;
               end
            endcase
            st.phases = {it.phase_a, it.phase_b};
         end
      end
      // speed at this item's time, zero when stale or with no period yet
      dt = elapsed_us(it.time_us, st.last_step);
      if (dt <= longint'({32'd0, c.stale_us}) && st.period != 0)
         rep.speed = clamp_s32(longint'({32'd0, c.speed_scale}) / longint'(st.period));
      rep.position    = st.position;
      rep.error_count = st.error_count;
      rep.period_us   = st.period;
      return rep;
   endfunction

   // queue a request, keeping the planning copy of the state in step
   task automatic queue_item(input encoder_item_type it);
      void'(decode_item(plan_state, cfg, it));
      encoder_items.push_back(it);
   endtask

   task automatic queue_direct(input logic op, input logic [62:0] t, input logic a,
                               input logic b, input logic [31:0] value);
      encoder_item_type it;
      it             = '0;
      it.opcode      = op;
      it.time_us     = t;
      it.phase_a     = a;
      it.phase_b     = b;
      it.load_value  = value;
      queue_item(it);
   endtask

   // random requests: mostly clean gray-code motion around the hold-off time
   task automatic queue_random(input int count);
      encoder_item_type it;
      logic [63:0]      t;
      logic [1:0]       p;
      logic [1:0]       step_fwd;
      logic [1:0]       step_bwd;
      int               roll;
      int               pick;
      bit               going_back;
      for (int n = 0; n < count; n++) begin
         it             = '0;
         it.drain_first = ($urandom_range(0, 99) == 0);
         going_back     = 1'b0;
         roll           = $urandom_range(0, 99);
         if (roll < 35)
            t = plan_state.last_step + 64'(cfg.min_gap_us)
                + 64'($urandom_range(1, 3 * cfg.min_gap_us + 20));
         else if (roll < 50)
            t = plan_state.last_step + 64'(cfg.min_gap_us) + 64'($urandom_range(0, 1));
         else if (roll < 65)
            t = plan_now + 64'($urandom_range(0, cfg.min_gap_us));
         else if (roll < 75)
            t = plan_state.last_step + 64'(cfg.stale_us) + 64'($urandom_range(0, 3)) - 64'd1;
         else if (roll < 80) begin
            // time going backwards
            going_back = 1'b1;
            if (plan_now > 64'd100000)
               t = plan_now - 64'($urandom_range(1, cfg.min_gap_us + 3));
            else
               t = plan_now;
         end else if (roll < 84)
            t = plan_now + {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
         else if (roll < 85)
            t = plan_now + ({32'($urandom), 32'($urandom)} >> 8);
         else
            t = plan_now + 64'($urandom_range(0, 20));
         if (!going_back && t < plan_now) t = plan_now;
         if (t[63]) t = plan_now;
         plan_now   = t;
         it.time_us = t[62:0];

         if ($urandom_range(0, 99) < 8) begin
            it.opcode = OP_LOAD;
            pick      = $urandom_range(0, 99);
            if (pick < 15)      it.load_value = SAT_MAX;
            else if (pick < 30) it.load_value = SAT_MIN;
            else                it.load_value = $urandom;
            {it.phase_a, it.phase_b} = 2'($urandom);
         end else begin
            it.opcode     = OP_SAMPLE;
            it.load_value = $urandom;
            if ($urandom_range(0, 99) < 3) plan_backward = ~plan_backward;
            p        = plan_state.phases;
            step_fwd = {~p[0], p[1]};
            step_bwd = {p[0], ~p[1]};
            pick     = $urandom_range(0, 99);
            if (pick < 78)      {it.phase_a, it.phase_b} = plan_backward ? step_bwd : step_fwd;
            else if (pick < 88) {it.phase_a, it.phase_b} = plan_backward ? step_fwd : step_bwd;
            else if (pick < 94) {it.phase_a, it.phase_b} = p;
            else                {it.phase_a, it.phase_b} = ~p;
         end
         queue_item(it);
      end
   endtask

   // control register write, only ever issued while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_HOLDOFF: cfg.min_gap_us  = data[15:0];
         CSR_STALE:   cfg.stale_us    = data;
         CSR_SCALE:   cfg.speed_scale = data;
         default: ;
      endcase
   endtask

   // wait for every queued request to be answered, then let the block settle
   task automatic wait_idle();
      while (encoder_items.size() != 0 || req_tvalid || predicted_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver: presents queued items, predicts on each accepted transaction
   always @(posedge clock) begin : request_driver
      logic busy;
      logic idle_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            predicted_reports.push_back(decode_item(track_state, cfg, item_on_bus));
            busy = 1'b0;
         end
         if (!busy) begin
            idle_now = (cycle_count[8:7] != 2'b00) && ($urandom_range(0, 99) < send_idle_pct);
            if (encoder_items.size() != 0 && !idle_now &&
                !(encoder_items[0].drain_first && predicted_reports.size() != 0)) begin
               item_on_bus = encoder_items.pop_front();
               req_tdata   <= {7'd0, item_on_bus.load_value, item_on_bus.phase_b,
                               item_on_bus.phase_a, item_on_bus.time_us};
               req_tuser   <= item_on_bus.opcode;
               req_tvalid  <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compares each accepted transaction with the oldest prediction
   always @(posedge clock) begin : response_monitor
      decoder_report_type want;
      decoder_report_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.position    = rsp_tdata[31:0];
            got.error_count = rsp_tdata[63:32];
            got.period_us   = rsp_tdata[95:64];
            got.speed       = rsp_tdata[127:96];
            got.kind        = qdec_kind_type'(rsp_tuser);
            if (predicted_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: pos %h err %h period %h kind %0d speed %h",
                           got.position, got.error_count, got.period_us, got.kind, got.speed);
            end else begin
               want = predicted_reports.pop_front();
               if (got.position != want.position || got.error_count != want.error_count ||
                   got.period_us != want.period_us || got.kind != want.kind ||
                   got.speed != want.speed) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected pos %h err %h period %h kind %0d speed %h",
                              want.position, want.error_count, want.period_us, want.kind,
                              want.speed);
                     $display("          got      pos %h err %h period %h kind %0d speed %h",
                              got.position, got.error_count, got.period_us, got.kind,
                              got.speed);
                  end
               end
            end
         end
         rsp_tready <= !((cycle_count[8:7] != 2'b00) &&
                         ($urandom_range(0, 99) < recv_stall_pct));
      end
   end

   // test sequence
   initial begin
      cfg.min_gap_us  = HOLDOFF_RESET;
      cfg.stale_us    = STALE_RESET;
      cfg.speed_scale = SCALE_RESET;
      track_state     = '0;
      plan_state      = '0;
      plan_now        = '0;
      plan_backward   = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: hold-off boundary, full turns both ways, illegal changes,
      // time going backwards, loads with wrap, stale boundary, long periods
      queue_direct(OP_SAMPLE, 63'd0,     1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd1000,  1'b1, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd1001,  1'b1, 1'b0, 32'hffff_ffff);
      queue_direct(OP_SAMPLE, 63'd2002,  1'b1, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd3003,  1'b0, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd4004,  1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd5005,  1'b0, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd6006,  1'b1, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd7007,  1'b1, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd8008,  1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd9009,  1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd10010, 1'b1, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd11011, 1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd12012, 1'b0, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd13013, 1'b1, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd14014, 1'b0, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd12011, 1'b1, 1'b1, 32'd0);
      queue_direct(OP_LOAD,   63'd15000, 1'b0, 1'b0, SAT_MAX);
      queue_direct(OP_SAMPLE, 63'd16000, 1'b0, 1'b0, 32'd0);
      queue_direct(OP_LOAD,   63'd16500, 1'b1, 1'b0, SAT_MIN);
      queue_direct(OP_SAMPLE, 63'd3016000, 1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd3016001, 1'b0, 1'b0, 32'd0);
      queue_direct(OP_SAMPLE, 63'd2147499653, 1'b0, 1'b1, 32'd0);
      queue_direct(OP_SAMPLE, 63'd1101659127429, 1'b0, 1'b0, 32'd0);
      queue_direct(OP_LOAD, 63'h7fff_ffff_ffff_ffff, 1'b1, 1'b1, $urandom);
      plan_now = plan_state.last_step;
      wait_idle();

      // extremes: no hold-off, never stale, largest scale so speed saturates
      write_csr(CSR_HOLDOFF, 32'd0);
      write_csr(CSR_STALE,   32'hffff_ffff);
      write_csr(CSR_SCALE,   32'hffff_ffff);
      queue_random(ITEMS_PER_PHASE);
      wait_idle();

      // other extremes with an idle sender
      write_csr(CSR_HOLDOFF, 32'd65535);
      write_csr(CSR_STALE,   32'd0);
      write_csr(CSR_SCALE,   32'd1);
      send_idle_pct = 67;
      queue_random(ITEMS_PER_PHASE);
      wait_idle();

      // random settings with a stalling receiver
      write_csr(CSR_HOLDOFF, $urandom_range(0, 300));
      write_csr(CSR_STALE,   $urandom_range(1000, 200000));
      write_csr(CSR_SCALE,   $urandom | 32'd1);
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      queue_random(ITEMS_PER_PHASE);
      wait_idle();

      // short hold-off, write to the unused index, light idling on both sides
      write_csr(CSR_HOLDOFF, 32'd10);
      write_csr(CSR_STALE,   32'd5000);
      write_csr(CSR_SCALE,   32'd1000000);
      write_csr(CSR_UNUSED,  $urandom);
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      queue_random(ITEMS_PER_PHASE);
      wait_idle();

      // defaults again with time moved into the upper half of its range
      write_csr(CSR_HOLDOFF, {16'd0, HOLDOFF_RESET});
      write_csr(CSR_STALE,   STALE_RESET);
      write_csr(CSR_SCALE,   SCALE_RESET);
      plan_now = plan_now + 64'h4000_0000_0000_0000 + ({32'($urandom), 32'($urandom)} >> 5);
      queue_random(ITEMS_PER_PHASE);
      wait_idle();

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
src/qdec_pkg.sv
src/qdec_csr.sv
src/qdec_div.sv
src/quadrature_decoder_with_speed_core.sv
bench/quadrature_decoder_with_speed_core_tb.sv
